>>> hw/rtl/pearson_correlation_macros.svh
// Assertion macros for the pearson_correlation block.
`ifndef PEARSON_CORRELATION_MACROS_SVH
`define PEARSON_CORRELATION_MACROS_SVH

// Check a property while out of reset.
`define PC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pearson_correlation check failed");

// Check a property at every edge, reset included.
`define PC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("pearson_correlation reset check failed");

`endif

>>> hw/rtl/pc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pc_pkg;
    localparam int MAX_PAIRS_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [1:0] REL_POS  = 2'd0;
    localparam logic [1:0] REL_NEG  = 2'd1;
    localparam logic [1:0] REL_NONE = 2'd2;

    typedef struct packed {
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
        logic               last_pair;
    } t_in;

    typedef struct packed {
        logic signed [15:0] correlation;
        logic [1:0]         relation;
        logic               undefined;
        logic               overflow;
    } t_out;
endpackage
`default_nettype wire

>>> hw/rtl/pc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pc_front #(
    parameter int MAX_PAIRS   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int JW          = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire pc_pkg::t_in   i_pair,
    output logic               o_job_push,
    output logic [JW-1:0]      o_job
);
    import pc_pkg::*;

    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam int SW = SAMPLE_BITS + CW;
    localparam int QW = 2 * SAMPLE_BITS + CW;

    logic [CW-1:0]        r_n,   n_n;
    logic signed [SW-1:0] r_sx,  n_sx,  r_sy,  n_sy;
    logic signed [QW-1:0] r_sxx, n_sxx, r_syy, n_syy, r_sxy, n_sxy;
    logic                 r_drop, n_drop;

    logic signed [SAMPLE_BITS-1:0]   x, y;
    logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;

    always_comb begin
        x     = i_pair.x_sample[SAMPLE_BITS-1:0];
        y     = i_pair.y_sample[SAMPLE_BITS-1:0];
        xx    = x * x;
        yy    = y * y;
        xy    = x * y;
        n_n   = r_n;
        n_sx  = r_sx;
        n_sy  = r_sy;
        n_sxx = r_sxx;
        n_syy = r_syy;
        n_sxy = r_sxy;
        n_drop = r_drop;
        if (r_n < CW'(MAX_PAIRS)) begin
            n_n   = r_n + CW'(1);
            n_sx  = r_sx + SW'(x);
            n_sy  = r_sy + SW'(y);
            n_sxx = r_sxx + QW'(xx);
            n_syy = r_syy + QW'(yy);
            n_sxy = r_sxy + QW'(xy);
        end else begin
            n_drop = 1'b1;
        end
    end

    assign o_job_push = i_accept && i_pair.last_pair;
    assign o_job = {n_drop, n_sxy, n_syy, n_sxx, n_sy, n_sx, n_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_job_push) begin
            r_n    <= '0;
            r_sx   <= '0;
            r_sy   <= '0;
            r_sxx  <= '0;
            r_syy  <= '0;
            r_sxy  <= '0;
            r_drop <= 1'b0;
        end else if (i_accept) begin
            r_n    <= n_n;
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_sxx  <= n_sxx;
            r_syy  <= n_syy;
            r_sxy  <= n_sxy;
            r_drop <= n_drop;
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/pc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module pc_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [NW-1:0]    r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/pc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pc_back #(
    parameter int MAX_PAIRS   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int JW          = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_empty,
    input  wire logic [JW-1:0] i_job,
    output logic               o_job_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output pc_pkg::t_out       o_result
);
    import pc_pkg::*;

    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam int SW = SAMPLE_BITS + CW;
    localparam int QW = 2 * SAMPLE_BITS + CW;
    localparam int VW = 2 * SAMPLE_BITS + 2 * CW + 1;
    localparam int MW = 2 * VW + 33;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [3:0] OP_NXY = 4'd0;
    localparam logic [3:0] OP_XY  = 4'd1;
    localparam logic [3:0] OP_NXX = 4'd2;
    localparam logic [3:0] OP_XX  = 4'd3;
    localparam logic [3:0] OP_NYY = 4'd4;
    localparam logic [3:0] OP_YY  = 4'd5;
    localparam logic [3:0] OP_VV  = 4'd6;
    localparam logic [3:0] OP_CC  = 4'd7;
    localparam logic [3:0] OP_TRY = 4'd8;

    logic [2:0]     r_state;
    logic [3:0]     r_op;
    logic [JW-1:0]  r_job;
    logic [MW-1:0]  r_ma, r_mb, r_acc;
    logic           r_neg;
    logic signed [MW-1:0] r_p, r_c, r_vx, r_vy, r_vv, r_rhs;
    logic [15:0]    r_q;
    logic [3:0]     r_bit;
    logic [31:0]    r_t;
    t_out           r_res, r_out;
    logic           r_ov;

    logic [CW-1:0]        j_n;
    logic signed [SW-1:0] j_sx, j_sy;
    logic signed [QW-1:0] j_sxx, j_syy, j_sxy;
    logic                 j_drop;
    logic signed [MW-1:0] e_n, e_sx, e_sy, e_sxx, e_syy, e_sxy;
    logic signed [MW-1:0] opa, opb, sp, diff;
    logic [MW-1:0]        abs_a, abs_b;
    logic [15:0]          trial, mag;

    assign {j_drop, j_sxy, j_syy, j_sxx, j_sy, j_sx, j_n} = r_job;

    always_comb begin
        e_n   = {{(MW - CW){1'b0}}, j_n};
        e_sx  = {{(MW - SW){j_sx[SW-1]}}, j_sx};
        e_sy  = {{(MW - SW){j_sy[SW-1]}}, j_sy};
        e_sxx = {{(MW - QW){j_sxx[QW-1]}}, j_sxx};
        e_syy = {{(MW - QW){j_syy[QW-1]}}, j_syy};
        e_sxy = {{(MW - QW){j_sxy[QW-1]}}, j_sxy};
        case (r_op)
            OP_NXY:  begin opa = e_n;  opb = e_sxy; end
            OP_XY:   begin opa = e_sx; opb = e_sy;  end
            OP_NXX:  begin opa = e_n;  opb = e_sxx; end
            OP_XX:   begin opa = e_sx; opb = e_sx;  end
            OP_NYY:  begin opa = e_n;  opb = e_syy; end
            OP_YY:   begin opa = e_sy; opb = e_sy;  end
            OP_VV:   begin opa = r_vx; opb = r_vy;  end
            OP_CC:   begin opa = r_c;  opb = r_c;   end
            default: begin opa = r_vv; opb = {{(MW - 32){1'b0}}, r_t}; end
        endcase
        abs_a = opa[MW-1] ? -opa : opa;
        abs_b = opb[MW-1] ? -opb : opb;
        sp    = r_neg ? -r_acc : r_acc;
        diff  = r_p - sp;
        trial = r_q | (16'd1 << r_bit);
        mag   = (r_q > 16'd32767) ? 16'd32767 : r_q;
    end

    assign o_job_pop = (r_state == S_IDLE) && !i_job_empty;
    assign o_empty   = !r_ov;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        case (r_state)
            S_LOAD: begin
                r_ma  <= abs_a;
                r_mb  <= abs_b;
                r_acc <= '0;
                r_neg <= opa[MW-1] ^ opb[MW-1];
            end
            S_MUL: begin
                if (r_mb != '0) begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                end
            end
            S_SQ: begin
                r_t <= trial * trial;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_NXY;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_ov || i_pop)) begin
                r_ov <= 1'b1;
            end else if (i_pop && r_ov) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_op    <= OP_NXY;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mb == '0) begin
                        r_op <= r_op + 4'd1;
                        r_res.overflow    <= j_drop;
                        r_res.correlation <= '0;
                        r_res.relation    <= REL_NONE;
                        case (r_op)
                            OP_NXY, OP_NXX, OP_NYY: begin
                                r_p     <= sp;
                                r_state <= S_LOAD;
                            end
                            OP_XY: begin
                                r_c     <= diff;
                                r_state <= S_LOAD;
                            end
                            OP_XX: begin
                                r_vx    <= diff;
                                r_state <= S_LOAD;
                            end
                            OP_YY: begin
                                r_vy <= diff;
                                r_res.undefined <= (r_vx == '0 || diff == '0);
                                if (r_vx == '0 || diff == '0 || r_c == '0) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_state <= S_LOAD;
                                end
                            end
                            OP_VV: begin
                                r_vv    <= sp;
                                r_state <= S_LOAD;
                            end
                            OP_CC: begin
                                r_rhs   <= sp <<< 30;
                                r_q     <= '0;
                                r_bit   <= 4'd15;
                                r_state <= S_SQ;
                            end
                            default: begin
                                if (r_acc <= r_rhs) begin
                                    r_q <= trial;
                                end
                                if (r_bit == '0) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_bit   <= r_bit - 4'd1;
                                    r_state <= S_SQ;
                                end
                            end
                        endcase
                    end
                end
                S_SQ: begin
                    r_op    <= OP_TRY;
                    r_state <= S_LOAD;
                end
                S_OUT: begin
                    if (!r_ov || i_pop) begin
                        r_out.overflow  <= r_res.overflow;
                        r_out.undefined <= r_res.undefined;
                        if (r_op > OP_CC) begin
                            r_out.correlation <= r_c[MW-1] ? -r_q : mag;
                            r_out.relation    <= r_c[MW-1] ? REL_NEG : REL_POS;
                        end else begin
                            r_out.correlation <= r_res.correlation;
                            r_out.relation    <= r_res.relation;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/pearson_correlation.sv
// Channel  | Handshake          | Beat
// ---------+--------------------+-----------------------------------------
// pairs    | push / full        | i_pair: x_sample, y_sample, last_pair
// results  | pop / empty        | o_result: correlation, relation, flags
//
// The front accumulates one pair per cycle while full is low; a last pair hands its
// sums to a two-entry job queue. The back runs one shift-add multiplier one bit per
// cycle: six products for covariance and variances, two for their product and the
// covariance squared, then, unless a variance or the covariance is zero, sixteen
// trial multiplies for the magnitude. full rises when the job queue holds two sets.
// Synchronous active-low reset clears all sums, the queue and the result slot.
`timescale 1ns / 1ps
`default_nettype none
module pearson_correlation #(
    parameter int MAX_PAIRS   = pc_pkg::MAX_PAIRS_DEF,
    parameter int SAMPLE_BITS = pc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire pc_pkg::t_in  i_pair,
    input  wire logic         pop,
    output logic              empty,
    output pc_pkg::t_out      o_result
);
    import pc_pkg::*;

    localparam int CW = $clog2(MAX_PAIRS + 1);
    localparam int SW = SAMPLE_BITS + CW;
    localparam int QW = 2 * SAMPLE_BITS + CW;
    localparam int JW = CW + 2 * SW + 3 * QW + 1;

    logic          job_push, job_pop, job_empty;
    logic [JW-1:0] job_in, job_out;

    pc_front #(.MAX_PAIRS(MAX_PAIRS), .SAMPLE_BITS(SAMPLE_BITS), .JW(JW)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !full),
        .i_pair     (i_pair),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    pc_queue #(.WIDTH(JW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    pc_back #(.MAX_PAIRS(MAX_PAIRS), .SAMPLE_BITS(SAMPLE_BITS), .JW(JW)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );
endmodule
`default_nettype wire

>>> hw/rtl/pc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "pearson_correlation_macros.svh"
module pc_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    input  wire logic         full,
    input  wire pc_pkg::t_in  i_pair,
    input  wire logic         pop,
    input  wire logic         empty,
    input  wire pc_pkg::t_out o_result
);
    import pc_pkg::*;

    logic undef_ok;
    logic ports_known;

    assign undef_ok    = (o_result.correlation == '0) && (o_result.relation == REL_NONE);
    assign ports_known = !$isunknown({push, full, pop, empty})
                         && (!push || !$isunknown(i_pair));

    `PC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> empty)
    `PC_ASSERT(a_undef_zero, (!empty && o_result.undefined) |-> undef_ok)
    `PC_ASSERT(a_sign_match, (!empty && o_result.relation == REL_POS) |-> !o_result.correlation[15])
    `PC_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(o_result)))
    `PC_ASSERT(a_known, ports_known)
endmodule

bind pearson_correlation pc_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .i_pair   (i_pair),
    .pop      (pop),
    .empty    (empty),
    .o_result (o_result)
);
`default_nettype wire
